// File: rtl/mrps_pkg.sv
// mrps_pkg: types and constants for the multichannel rate pulse source.
// No dependencies; imported by multichannel_rate_pulse_source.
`timescale 1ns / 1ps
`default_nettype none

package mrps_pkg;

	localparam int NUM_REGS   = 4;
	localparam int REG_IDX_W  = 2;
	localparam int ADDR_W     = 4;
	localparam int RATE_W     = 16;
	localparam int MS_W       = 14;
	localparam int PROD_W     = RATE_W + MS_W;   // rate * ms
	localparam int SUM_W      = PROD_W + 1;      // plus carried fraction
	localparam int FRAC_W     = 20;              // fraction stays below one pulse
	localparam int EMIT_W     = 11;              // pulses per window stay below 2048
	localparam int CNT_W      = 16;
	localparam int TIME_W     = 32;
	localparam int ITER_W     = 6;
	localparam int MUL_W      = 24;

	// sum/960000 = (sum >> 8) / 3750; the shifted sum is below 2^23, so a
	// 24-bit reciprocal rounded up with a 35-bit shift gives the exact floor
	localparam int PRE_SH     = 8;
	localparam int RECIP_SH   = 35;

	localparam logic [FRAC_W-1:0] UNITS_PER_PULSE = 20'd960000;
	localparam logic [MUL_W-1:0]  RECIP_UNITS     = 24'd9162597;
	localparam logic [9:0]        US_PER_MS       = 10'd1000;
	localparam logic [ITER_W-1:0] ITER_PERIOD     = 6'd32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_DIVC,
		ST_EMIT,
		ST_DIVP,
		ST_PER,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic div_step;
		logic out_load;
		logic busy;
	} ctrl_t;

endpackage

`default_nettype wire

// File: rtl/multichannel_rate_pulse_source.sv
// Multichannel rate pulse source, top level.
// Uses mrps_pkg; holds the sequencer, the shared multiplier and divider and channel state.
//
// Usage: each input word (win_ms) is one time window. The block advances a
// microsecond clock, adds rate*win_ms to each channel's fractional pulse
// accumulator, emits whole pulses into a wrapping count and updates the pulse
// period. It then sends one output word per channel, channel 0 first, with
// last_channel set on the final one.
// Channels are worked one after the other through one shared multiplier (rate
// times window, reciprocal divide by the pulse unit, remainder) and one
// bit-per-cycle divider that runs 32 steps for the period, only when a channel
// emits after its first pulse. Each channel runs ST_MUL, ST_ADD, ST_DIVC and
// ST_EMIT, then ST_DIVP and ST_PER when it divides, then ST_REPORT, which loads
// its output word. An input word keeps in_stall high until the last channel's
// word is loaded, and the next word can be taken on the cycle after.
// Output words sit in a single output register; while out_stall is high the
// word is held and the sequencer waits in ST_REPORT with the next channel's word.
// Target rates must be written over the APB port while idle; the block never checks.
// Reset clears all rates, counts, periods and the clock; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_rate_pulse_source
	import mrps_pkg::*;
#(
	parameter int CHANNELS = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// APB configuration
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_W-1:0]    paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready,
	// input words
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [MS_W-1:0]      win_ms,
	// output words
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [1:0]           channel_index,
	output logic      [CNT_W-1:0]     pulse_count,
	output logic      [TIME_W-1:0]    pulse_period,
	output logic                      last_channel
);

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	state_t state_q, state_d;
	ctrl_t  ctrl;

	logic [RATE_W-1:0]   rate_q [NUM_REGS];
	logic [TIME_W-1:0]   vtime_q;
	logic [MS_W-1:0]     ms_q;
	logic [CH_IDX_W-1:0] ch_q;
	logic [PROD_W-1:0]   prod_q;
	logic [SUM_W-1:0]    sum_q;

	logic [FRAC_W-1:0]   acc_q    [CHANNELS];
	logic [CNT_W-1:0]    pcnt_q   [CHANNELS];
	logic                seen_q   [CHANNELS];
	logic [TIME_W-1:0]   lpt_q    [CHANNELS];
	logic [TIME_W-1:0]   lper_q   [CHANNELS];

	// shared divider: remainder, dividend/quotient shift word, divisor, step count
	logic [FRAC_W-1:0]   rem_q;
	logic [TIME_W-1:0]   dq_q;
	logic [FRAC_W-1:0]   den_q;
	logic [ITER_W-1:0]   iter_q;

	logic                out_valid_q;
	logic [1:0]          out_ch_q;
	logic [CNT_W-1:0]    out_cnt_q;
	logic [TIME_W-1:0]   out_per_q;
	logic                out_last_q;

	logic                in_fire;
	logic                cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;
	logic [REG_IDX_W-1:0] rate_idx;
	logic                last_ch;
	logic                out_free;

	logic [MUL_W-1:0]    mul_a;
	logic [MUL_W-1:0]    mul_b;
	logic [2*MUL_W-1:0]  mul_p;

	logic [FRAC_W:0]     trial;
	logic                trial_ge;
	logic [FRAC_W:0]     trial_diff;
	logic [SUM_W-1:0]    sum;
	logic [EMIT_W-1:0]   emit;
	logic [TIME_W-1:0]   span;
	logic [TIME_W-1:0]   since;
	logic [TIME_W:0]     limit;
	logic [TIME_W-1:0]   rep_period;

	assign in_fire  = in_valid && !in_stall;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign cfg_idx  = paddr[ADDR_W-1:2];
	assign rate_idx = REG_IDX_W'(ch_q);
	assign last_ch  = (ch_q == CH_IDX_W'(CHANNELS - 1));
	assign out_free = !out_valid_q || !out_stall;

	assign pready = 1'b1;
	assign prdata = {{(32-RATE_W){1'b0}}, rate_q[cfg_idx]};

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL: begin
				mul_a = MUL_W'(rate_q[rate_idx]);
				mul_b = MUL_W'(ms_q);
			end
			ST_DIVC: begin
				mul_a = MUL_W'(sum_q[SUM_W-1:PRE_SH]);
				mul_b = RECIP_UNITS;
			end
			ST_EMIT: begin
				mul_a = MUL_W'(emit);
				mul_b = MUL_W'(UNITS_PER_PULSE);
			end
			default: ;
		endcase
	end

	assign mul_p = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

	// one restoring division step
	assign trial      = {rem_q, dq_q[TIME_W-1]};
	assign trial_diff = trial - {1'b0, den_q};
	assign trial_ge   = (trial >= {1'b0, den_q});

	assign sum  = SUM_W'(prod_q) + SUM_W'(acc_q[ch_q]);
	assign emit = dq_q[EMIT_W-1:0];
	assign span = vtime_q - lpt_q[ch_q];

	// stale test: more than 1.5 periods since the last pulse reads as zero
	assign since = vtime_q - lpt_q[ch_q];
	assign limit = {1'b0, lper_q[ch_q]} + {2'b0, lper_q[ch_q][TIME_W-1:1]};
	assign rep_period = (!seen_q[ch_q] || ({1'b0, since} > limit)) ? '0 : lper_q[ch_q];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_MUL;
			end
			ST_MUL:  state_d = ST_ADD;
			ST_ADD:  state_d = ST_DIVC;
			ST_DIVC: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit != '0 && seen_q[ch_q]) state_d = ST_DIVP;
				else                            state_d = ST_REPORT;
			end
			ST_DIVP: begin
				if (iter_q == ITER_W'(1)) state_d = ST_PER;
			end
			ST_PER:  state_d = ST_REPORT;
			ST_REPORT: begin
				if (out_free) state_d = last_ch ? ST_IDLE : ST_MUL;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE:   ctrl.busy = 1'b0;
			ST_DIVP: begin
				ctrl.busy     = 1'b1;
				ctrl.div_step = 1'b1;
			end
			ST_REPORT: begin
				ctrl.busy     = 1'b1;
				ctrl.out_load = out_free;
			end
			default:   ctrl.busy = 1'b1;
		endcase
	end

	assign in_stall = ctrl.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) rate_q[i] <= '0;
		end else if (cfg_wr) begin
			rate_q[cfg_idx] <= pwdata[RATE_W-1:0];
		end
	end

	// clock, channel pointer and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtime_q <= '0;
			ch_q    <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				acc_q[i]  <= '0;
				pcnt_q[i] <= '0;
				seen_q[i] <= 1'b0;
				lpt_q[i]  <= '0;
				lper_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_IDLE && in_fire) begin
				vtime_q <= vtime_q + TIME_W'(win_ms) * TIME_W'(US_PER_MS);
				ch_q    <= '0;
			end
			if (state_q == ST_EMIT) begin
				// multiplier holds emit * UNITS_PER_PULSE here
				acc_q[ch_q]  <= FRAC_W'(sum_q - mul_p[SUM_W-1:0]);
				pcnt_q[ch_q] <= pcnt_q[ch_q] + CNT_W'(emit);
				if (emit != '0) begin
					lpt_q[ch_q]  <= vtime_q;
					seen_q[ch_q] <= 1'b1;
				end
			end
			if (state_q == ST_PER) lper_q[ch_q] <= dq_q;
			if (ctrl.out_load && !last_ch) ch_q <= ch_q + CH_IDX_W'(1);
		end
	end

	// datapath words
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_fire) ms_q <= win_ms;
		if (state_q == ST_MUL) prod_q <= mul_p[PROD_W-1:0];
		if (state_q == ST_ADD) sum_q <= sum;
		if (state_q == ST_DIVC) begin
			// quotient is below 2048
			dq_q   <= TIME_W'(mul_p[RECIP_SH +: EMIT_W]);
		end else if (state_q == ST_EMIT) begin
			rem_q  <= '0;
			dq_q   <= span;
			den_q  <= FRAC_W'(emit);
			iter_q <= ITER_PERIOD;
		end else if (ctrl.div_step) begin
			rem_q  <= trial_ge ? trial_diff[FRAC_W-1:0] : trial[FRAC_W-1:0];
			dq_q   <= {dq_q[TIME_W-2:0], trial_ge};
			iter_q <= iter_q - ITER_W'(1);
		end
		if (ctrl.out_load) begin
			out_ch_q   <= 2'(ch_q);
			out_cnt_q  <= pcnt_q[ch_q];
			out_per_q  <= rep_period;
			out_last_q <= last_ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign channel_index = out_ch_q;
	assign pulse_count   = out_cnt_q;
	assign pulse_period  = out_per_q;
	assign last_channel  = out_last_q;

endmodule

`default_nettype wire
